// ----- hdl/fcw_pkg.sv -----
`timescale 1ns / 1ps

package fcw_pkg;

   localparam int TABLE_ENTRIES = 4096;
   localparam int SECTOR_BYTES  = 512;

   localparam int ENTRY_W   = 12;
   localparam int PAIR_W    = 11;
   localparam int BYTES_W   = 24;
   localparam int SIZE_W    = 32;
   localparam int BASE_W    = 24;
   localparam int ADDR_W    = 25;
   localparam int LEN_W     = 10;
   localparam int KIND_W    = 2;

   localparam int TABLE_ROWS   = TABLE_ENTRIES / 2;
   localparam int ROW_W        = 2 * ENTRY_W;
   localparam int ROW_AW       = $clog2(TABLE_ROWS);
   localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
   localparam int LEN_CALC_W   = $clog2(SECTOR_BYTES + 1);

   localparam logic [BASE_W-1:0] DATA_BASE_RESET = 24'h003e00;

   localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_START = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NEXT  = 2'd2;

   localparam logic STATUS_SEGMENT = 1'b0;
   localparam logic STATUS_IDLE    = 1'b1;

   typedef struct packed {
      logic                push;
      logic                status;
      logic [ENTRY_W-1:0]  cluster;
      logic [ADDR_W-1:0]   segment_address;
      logic [LEN_W-1:0]    segment_length;
      logic                last;
   } seg_type;

endpackage

// ----- hdl/fcw_ram.sv -----
`timescale 1ns / 1ps

module fcw_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/fcw_ctrl.sv -----
`timescale 1ns / 1ps

module fcw_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [fcw_pkg::KIND_W-1:0]          req_kind,
   input  logic [fcw_pkg::PAIR_W-1:0]          req_pair_index,
   input  logic [fcw_pkg::BYTES_W-1:0]         req_packed_bytes,
   input  logic [fcw_pkg::ENTRY_W-1:0]         req_start_cluster,
   input  logic [fcw_pkg::SIZE_W-1:0]          req_file_size,
   input  logic                                out_free,
   input  logic [fcw_pkg::BASE_W-1:0]          data_base,
   output fcw_pkg::seg_type                    seg,
   output logic                                wr_en,
   output logic [fcw_pkg::ROW_AW-1:0]          wr_addr,
   output logic [fcw_pkg::ROW_W-1:0]           wr_data,
   output logic [fcw_pkg::ROW_AW-1:0]          rd_addr,
   input  logic [fcw_pkg::ROW_W-1:0]           rd_data
);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_FETCH = 2'b10
   } state_type;

   state_type                          state_ff, state_in;
   logic [fcw_pkg::ENTRY_W-1:0]        cluster_ff, cluster_in;
   logic [fcw_pkg::SIZE_W-1:0]         remaining_ff, remaining_in;

   logic                               accept;
   logic [fcw_pkg::LEN_CALC_W-1:0]     len_calc;
   logic                               seg_last;
   logic [fcw_pkg::ADDR_W-1:0]         seg_addr;
   logic [fcw_pkg::ENTRY_W-1:0]        next_entry;
   logic                               read_in_range;
   logic                               pair_in_range;
   logic [7:0]                         byte0, byte1, byte2;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;

   assign len_calc = (remaining_ff < fcw_pkg::SIZE_W'(fcw_pkg::SECTOR_BYTES))
                   ? remaining_ff[fcw_pkg::LEN_CALC_W-1:0]
                   : fcw_pkg::LEN_CALC_W'(fcw_pkg::SECTOR_BYTES);
   assign seg_last = remaining_ff <= fcw_pkg::SIZE_W'(fcw_pkg::SECTOR_BYTES);
   assign seg_addr = fcw_pkg::ADDR_W'(data_base)
                   + (fcw_pkg::ADDR_W'(cluster_ff) << fcw_pkg::SECTOR_SHIFT);

   // unpack three little-endian bytes into an even and an odd entry
   assign byte0   = req_packed_bytes[7:0];
   assign byte1   = req_packed_bytes[15:8];
   assign byte2   = req_packed_bytes[23:16];
   assign wr_data = {byte2, byte1[7:4], byte1[3:0], byte0};
   assign wr_addr = req_pair_index[fcw_pkg::ROW_AW-1:0];
   assign pair_in_range = {1'b0, req_pair_index} < (fcw_pkg::PAIR_W + 1)'(fcw_pkg::TABLE_ROWS);

   assign rd_addr       = cluster_ff[fcw_pkg::ROW_AW:1];
   assign read_in_range = {1'b0, cluster_ff}
                        < (fcw_pkg::ENTRY_W + 1)'(fcw_pkg::TABLE_ENTRIES);
   assign next_entry    = cluster_ff[0] ? rd_data[fcw_pkg::ROW_W-1:fcw_pkg::ENTRY_W]
                                        : rd_data[fcw_pkg::ENTRY_W-1:0];

   always_comb begin
      state_in     = state_ff;
      cluster_in   = cluster_ff;
      remaining_in = remaining_ff;
      wr_en        = 1'b0;
      seg          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  fcw_pkg::KIND_LOAD: begin
                     wr_en = pair_in_range;
                  end
                  fcw_pkg::KIND_START: begin
                     cluster_in   = req_start_cluster;
                     remaining_in = req_file_size;
                  end
                  fcw_pkg::KIND_NEXT: begin
                     seg.push = 1'b1;
                     if (remaining_ff == '0) begin
                        seg.status = fcw_pkg::STATUS_IDLE;
                     end else begin
                        seg.status          = fcw_pkg::STATUS_SEGMENT;
                        seg.cluster         = cluster_ff;
                        seg.segment_address = seg_addr;
                        seg.segment_length  = fcw_pkg::LEN_W'(len_calc);
                        seg.last            = seg_last;
                        remaining_in = remaining_ff - fcw_pkg::SIZE_W'(len_calc);
                        state_in     = ST_FETCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FETCH: begin
            // follow the chain from the entry read during acceptance
            cluster_in = read_in_range ? next_entry : '0;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cluster_ff   <= '0;
         remaining_ff <= '0;
      end else begin
         state_ff     <= state_in;
         cluster_ff   <= cluster_in;
         remaining_ff <= remaining_in;
      end
   end

endmodule

// ----- hdl/fat12_cluster_chain_walker_core.sv -----
`timescale 1ns / 1ps

// FAT12 cluster chain walker.
// Request channel (req_*): one transaction per item. kind selects a table
// load (pair_index, packed_bytes), a file start (start_cluster, file_size)
// or a next-segment request. Load and start produce no response.
// Response channel (rsp_*): one transaction per next request, giving the
// segment's cluster, data address, length and last flag, or status 1 with
// all other fields zero once no bytes remain.
// CSR channel (csr_*): writes data_base; always ready. Write only while idle.
// The response is registered in the cycle after the request is taken.
// Load and start leave the walker ready for another request; a next request
// yielding a segment holds off requests through the fetch state, as the table
// RAM read of the current cluster must return before the chain can advance.
// A new request is taken only while the response register is empty or being
// drained, so a stalled receiver holds off further requests.
// Reset clears the walk state and restores data_base; table contents are
// undefined until loaded.

module fat12_cluster_chain_walker_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [fcw_pkg::KIND_W-1:0]          req_kind,
   input  logic [fcw_pkg::PAIR_W-1:0]          req_pair_index,
   input  logic [fcw_pkg::BYTES_W-1:0]         req_packed_bytes,
   input  logic [fcw_pkg::ENTRY_W-1:0]         req_start_cluster,
   input  logic [fcw_pkg::SIZE_W-1:0]          req_file_size,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_status,
   output logic [fcw_pkg::ENTRY_W-1:0]         rsp_cluster,
   output logic [fcw_pkg::ADDR_W-1:0]          rsp_segment_address,
   output logic [fcw_pkg::LEN_W-1:0]           rsp_segment_length,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fcw_pkg::BASE_W-1:0]          csr_data_base
);

   logic [fcw_pkg::BASE_W-1:0]   data_base_ff;
   logic                         rsp_valid_ff;
   fcw_pkg::seg_type             rsp_ff;
   fcw_pkg::seg_type             seg;
   logic                         out_free;
   logic                         wr_en;
   logic [fcw_pkg::ROW_AW-1:0]   wr_addr;
   logic [fcw_pkg::ROW_W-1:0]    wr_data;
   logic [fcw_pkg::ROW_AW-1:0]   rd_addr;
   logic [fcw_pkg::ROW_W-1:0]    rd_data;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   fcw_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_pair_index    (req_pair_index),
      .req_packed_bytes  (req_packed_bytes),
      .req_start_cluster (req_start_cluster),
      .req_file_size     (req_file_size),
      .out_free          (out_free),
      .data_base         (data_base_ff),
      .seg               (seg),
      .wr_en             (wr_en),
      .wr_addr           (wr_addr),
      .wr_data           (wr_data),
      .rd_addr           (rd_addr),
      .rd_data           (rd_data)
   );

   fcw_ram #(
      .WIDTH (fcw_pkg::ROW_W),
      .DEPTH (fcw_pkg::TABLE_ROWS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         data_base_ff <= fcw_pkg::DATA_BASE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            data_base_ff <= csr_data_base;
         end
         if (seg.push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // hold the response payload until the transaction completes
   always_ff @(posedge clock) begin
      if (seg.push) begin
         rsp_ff <= seg;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_ff.status;
   assign rsp_cluster         = rsp_ff.cluster;
   assign rsp_segment_address = rsp_ff.segment_address;
   assign rsp_segment_length  = rsp_ff.segment_length;
   assign rsp_last            = rsp_ff.last;

endmodule

// ----- hdl/fcw_checker.sv -----
`timescale 1ns / 1ps

module fcw_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_status,
   input logic [fcw_pkg::ENTRY_W-1:0]         rsp_cluster,
   input logic [fcw_pkg::ADDR_W-1:0]          rsp_segment_address,
   input logic [fcw_pkg::LEN_W-1:0]           rsp_segment_length,
   input logic                                rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_cluster) && $stable(rsp_segment_address)
         && $stable(rsp_segment_length) && $stable(rsp_last))
      else $error("response changed while stalled");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == fcw_pkg::STATUS_IDLE |->
         rsp_cluster == '0 && rsp_segment_address == '0
         && rsp_segment_length == '0 && !rsp_last)
      else $error("idle response carries segment fields");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == fcw_pkg::STATUS_SEGMENT |->
         rsp_segment_length != '0
         && rsp_segment_length <= fcw_pkg::LEN_W'(fcw_pkg::SECTOR_BYTES))
      else $error("segment length out of range");

   a_full_unless_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == fcw_pkg::STATUS_SEGMENT && !rsp_last |->
         rsp_segment_length == fcw_pkg::LEN_W'(fcw_pkg::SECTOR_BYTES))
      else $error("short segment not marked last");

endmodule

bind fat12_cluster_chain_walker_core fcw_checker u_fcw_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_status          (rsp_status),
   .rsp_cluster         (rsp_cluster),
   .rsp_segment_address (rsp_segment_address),
   .rsp_segment_length  (rsp_segment_length),
   .rsp_last            (rsp_last)
);

// ----- tb/fat12_cluster_chain_walker_core_tb.sv -----
`timescale 1ns / 1ps

module fat12_cluster_chain_walker_core_tb;

   localparam int          PHASES        = 6;
   localparam int          PHASE_ITEMS   = 320;
   localparam int          SETTLE_CYCLES = 4;
   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int          PRINT_LIMIT   = 100;

   localparam logic [fcw_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef struct {
      logic [fcw_pkg::KIND_W-1:0]  kind;
      logic [fcw_pkg::PAIR_W-1:0]  pair_index;
      logic [fcw_pkg::BYTES_W-1:0] packed_bytes;
      logic [fcw_pkg::ENTRY_W-1:0] start_cluster;
      logic [fcw_pkg::SIZE_W-1:0]  file_size;
   } chain_req_type;

   typedef struct {
      logic                        status;
      logic [fcw_pkg::ENTRY_W-1:0] cluster;
      logic [fcw_pkg::ADDR_W-1:0]  segment_address;
      logic [fcw_pkg::LEN_W-1:0]   segment_length;
      logic                        last;
   } segment_type;

   logic                         clock;
   logic                         reset               = 1'b1;
   logic                         req_valid           = 1'b0;
   logic                         req_ready;
   logic [fcw_pkg::KIND_W-1:0]   req_kind            = '0;
   logic [fcw_pkg::PAIR_W-1:0]   req_pair_index      = '0;
   logic [fcw_pkg::BYTES_W-1:0]  req_packed_bytes    = '0;
   logic [fcw_pkg::ENTRY_W-1:0]  req_start_cluster   = '0;
   logic [fcw_pkg::SIZE_W-1:0]   req_file_size       = '0;
   logic                         rsp_valid;
   logic                         rsp_ready           = 1'b0;
   logic                         rsp_status;
   logic [fcw_pkg::ENTRY_W-1:0]  rsp_cluster;
   logic [fcw_pkg::ADDR_W-1:0]   rsp_segment_address;
   logic [fcw_pkg::LEN_W-1:0]    rsp_segment_length;
   logic                         rsp_last;
   logic                         csr_valid           = 1'b0;
   logic                         csr_ready;
   logic [fcw_pkg::BASE_W-1:0]   csr_data_base       = '0;

   // stimulus planning: shadow of the table as loaded, and of the walk as issued
   logic [fcw_pkg::ENTRY_W-1:0]  plan_entry [fcw_pkg::TABLE_ENTRIES];
   bit                           plan_loaded [fcw_pkg::TABLE_ENTRIES];
   logic [fcw_pkg::ENTRY_W-1:0]  plan_cluster = '0;
   logic [fcw_pkg::SIZE_W-1:0]   plan_left    = '0;
   int                           plan_items   = 0;
   chain_req_type                req_pending [$];

   // segment prediction on accepted transactions
   logic [fcw_pkg::ENTRY_W-1:0]  walk_entry [fcw_pkg::TABLE_ENTRIES];
   logic [fcw_pkg::ENTRY_W-1:0]  walk_cluster = '0;
   logic [fcw_pkg::SIZE_W-1:0]   walk_left    = '0;
   logic [fcw_pkg::BASE_W-1:0]   walk_base    = fcw_pkg::DATA_BASE_RESET;
   segment_type                  seg_expect [$];

   chain_req_type                req_now;
   int                           req_gap      = 0;
   int                           rsp_hold     = 0;
   int                           idle_pct     = 0;
   int                           fail_count   = 0;
   int unsigned                  cycle_count  = 0;

   fat12_cluster_chain_walker_core u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_pair_index      (req_pair_index),
      .req_packed_bytes    (req_packed_bytes),
      .req_start_cluster   (req_start_cluster),
      .req_file_size       (req_file_size),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_cluster         (rsp_cluster),
      .rsp_segment_address (rsp_segment_address),
      .rsp_segment_length  (rsp_segment_length),
      .rsp_last            (rsp_last),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_data_base       (csr_data_base)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic note_failure(input string msg);
      if (fail_count < PRINT_LIMIT) begin
         $display("%0t ERROR: %s", $realtime, msg);
      end
      fail_count++;
   endtask

   function automatic chain_req_type random_item(input logic [fcw_pkg::KIND_W-1:0] kind);
      chain_req_type it;
      it.kind          = kind;
      it.pair_index    = fcw_pkg::PAIR_W'($urandom);
      it.packed_bytes  = fcw_pkg::BYTES_W'($urandom);
      it.start_cluster = fcw_pkg::ENTRY_W'($urandom);
      it.file_size     = $urandom;
      return it;
   endfunction

   function automatic void queue_pair(input logic [fcw_pkg::PAIR_W-1:0] pair,
                                      input logic [fcw_pkg::ENTRY_W-1:0] even_val,
                                      input logic [fcw_pkg::ENTRY_W-1:0] odd_val);
      chain_req_type it;
      it = random_item(fcw_pkg::KIND_LOAD);
      it.pair_index   = pair;
      it.packed_bytes = {odd_val, even_val};
      req_pending.push_back(it);
      plan_entry[{pair, 1'b0}]  = even_val;
      plan_entry[{pair, 1'b1}]  = odd_val;
      plan_loaded[{pair, 1'b0}] = 1'b1;
      plan_loaded[{pair, 1'b1}] = 1'b1;
      plan_items++;
   endfunction

   // write one entry, keeping its partner in the pair as already loaded
   function automatic void set_entry(input logic [fcw_pkg::ENTRY_W-1:0] idx,
                                     input logic [fcw_pkg::ENTRY_W-1:0] val);
      logic [fcw_pkg::ENTRY_W-1:0] partner;
      logic [fcw_pkg::ENTRY_W-1:0] other;
      partner = {idx[fcw_pkg::ENTRY_W-1:1], ~idx[0]};
      other   = plan_loaded[partner] ? plan_entry[partner]
                                     : fcw_pkg::ENTRY_W'($urandom);
      if (idx[0]) begin
         queue_pair(idx[fcw_pkg::ENTRY_W-1:1], other, val);
      end else begin
         queue_pair(idx[fcw_pkg::ENTRY_W-1:1], val, other);
      end
   endfunction

   function automatic void queue_start(input logic [fcw_pkg::ENTRY_W-1:0] first,
                                       input logic [fcw_pkg::SIZE_W-1:0] size);
      chain_req_type it;
      it = random_item(fcw_pkg::KIND_START);
      it.start_cluster = first;
      it.file_size     = size;
      req_pending.push_back(it);
      plan_cluster = first;
      plan_left    = size;
      plan_items++;
   endfunction

   function automatic void queue_next();
      logic [fcw_pkg::SIZE_W-1:0] take;
      if (plan_left != 0) begin
         // load the current entry first so the chain read never hits an empty slot
         if (!plan_loaded[plan_cluster]) begin
            set_entry(plan_cluster, fcw_pkg::ENTRY_W'($urandom));
         end
         take = (plan_left < fcw_pkg::SECTOR_BYTES)
              ? plan_left : fcw_pkg::SIZE_W'(fcw_pkg::SECTOR_BYTES);
         plan_left    = plan_left - take;
         plan_cluster = plan_entry[plan_cluster];
      end
      req_pending.push_back(random_item(fcw_pkg::KIND_NEXT));
      plan_items++;
   endfunction

   function automatic void queue_stray();
      req_pending.push_back(random_item(KIND_UNUSED));
   endfunction

   function automatic void queue_noise();
      case ($urandom_range(5))
         0: queue_pair(fcw_pkg::PAIR_W'($urandom), fcw_pkg::ENTRY_W'($urandom),
                       fcw_pkg::ENTRY_W'($urandom));
         1: queue_stray();
         2: begin
            queue_start(fcw_pkg::ENTRY_W'($urandom), $urandom);
            repeat ($urandom_range(1, 4)) queue_next();
         end
         3: begin
            queue_start(fcw_pkg::ENTRY_W'($urandom),
                        fcw_pkg::SIZE_W'($urandom_range(0, 1100)));
            repeat ($urandom_range(0, 4)) queue_next();
         end
         default: queue_next();
      endcase
   endfunction

   function automatic void queue_file(input int clusters);
      logic [fcw_pkg::ENTRY_W-1:0] first, here, ahead;
      first = fcw_pkg::ENTRY_W'($urandom);
      here  = first;
      for (int i = 1; i < clusters; i++) begin
         ahead = fcw_pkg::ENTRY_W'($urandom);
         set_entry(here, ahead);
         here = ahead;
      end
      set_entry(here, ($urandom_range(3) == 0) ? fcw_pkg::ENTRY_W'($urandom) : 12'hfff);
      queue_start(first, fcw_pkg::SIZE_W'((clusters - 1) * fcw_pkg::SECTOR_BYTES
                                 + $urandom_range(1, fcw_pkg::SECTOR_BYTES)));
      for (int i = 0; i < clusters; i++) begin
         if ($urandom_range(9) == 0) begin
            queue_noise();
         end
         queue_next();
      end
      repeat ($urandom_range(0, 2)) queue_next();
   endfunction

   function automatic void queue_directed();
      queue_next();
      queue_stray();
      queue_pair(11'd0, 12'hfff, 12'hfff);
      queue_pair(11'd2047, 12'h000, 12'h000);
      queue_pair(11'd1, 12'h000, 12'hfff);
      queue_start(12'hfff, 32'hffff_ffff);
      repeat (3) queue_next();
      queue_start(12'h000, 32'd1);
      repeat (2) queue_next();
      queue_start(12'h002, 32'd513);
      repeat (3) queue_next();
      queue_start(12'h003, 32'd512);
      repeat (2) queue_next();
      queue_start(12'habc, 32'd0);
      queue_next();
   endfunction

   function automatic void predict_item(input chain_req_type it);
      segment_type                seg;
      logic [fcw_pkg::SIZE_W-1:0] take;
      logic [7:0]                 b0, b1, b2;
      b0 = it.packed_bytes[7:0];
      b1 = it.packed_bytes[15:8];
      b2 = it.packed_bytes[23:16];
      case (it.kind)
         fcw_pkg::KIND_LOAD: begin
            walk_entry[{it.pair_index, 1'b0}] = {b1[3:0], b0};
            walk_entry[{it.pair_index, 1'b1}] = {b2, b1[7:4]};
         end
         fcw_pkg::KIND_START: begin
            walk_cluster = it.start_cluster;
            walk_left    = it.file_size;
         end
         fcw_pkg::KIND_NEXT: begin
            if (walk_left == 0) begin
               seg = '{fcw_pkg::STATUS_IDLE, '0, '0, '0, 1'b0};
            end else begin
               take      = (walk_left < fcw_pkg::SECTOR_BYTES)
                         ? walk_left : fcw_pkg::SIZE_W'(fcw_pkg::SECTOR_BYTES);
               walk_left = walk_left - take;
               seg.status          = fcw_pkg::STATUS_SEGMENT;
               seg.cluster         = walk_cluster;
               seg.segment_address = fcw_pkg::ADDR_W'(walk_base)
                                     + fcw_pkg::ADDR_W'(walk_cluster)
                                     * fcw_pkg::ADDR_W'(fcw_pkg::SECTOR_BYTES);
               seg.segment_length  = take[fcw_pkg::LEN_W-1:0];
               seg.last            = (walk_left == 0);
               walk_cluster        = walk_entry[walk_cluster];
            end
            seg_expect.push_back(seg);
         end
         default: ;
      endcase
   endfunction

   task automatic check_segment(input segment_type got);
      segment_type want;
      if (seg_expect.size() == 0) begin
         note_failure($sformatf("response with nothing pending, cluster %0h", got.cluster));
      end else begin
         want = seg_expect.pop_front();
         if (got.status !== want.status)
            note_failure($sformatf("status got %0h want %0h", got.status, want.status));
         if (got.cluster !== want.cluster)
            note_failure($sformatf("cluster got %0h want %0h", got.cluster, want.cluster));
         if (got.segment_address !== want.segment_address)
            note_failure($sformatf("segment_address got %0h want %0h",
                                   got.segment_address, want.segment_address));
         if (got.segment_length !== want.segment_length)
            note_failure($sformatf("segment_length got %0d want %0d",
                                   got.segment_length, want.segment_length));
         if (got.last !== want.last)
            note_failure($sformatf("last got %0h want %0h", got.last, want.last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_item(req_now);
         end
         if (!req_valid || req_ready) begin
            if (req_gap != 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
               req_gap = $urandom_range(0, 5);
               req_valid <= 1'b0;
            end else if (req_pending.size() != 0) begin
               req_now = req_pending.pop_front();
               req_kind          <= req_now.kind;
               req_pair_index    <= req_now.pair_index;
               req_packed_bytes  <= req_now.packed_bytes;
               req_start_cluster <= req_now.start_cluster;
               req_file_size     <= req_now.file_size;
               req_valid         <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_segment(segment_type'{rsp_status, rsp_cluster, rsp_segment_address,
                                        rsp_segment_length, rsp_last});
         end
         if (rsp_hold != 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            rsp_hold = $urandom_range(0, 5);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic write_base(input logic [fcw_pkg::BASE_W-1:0] value);
      csr_valid     <= 1'b1;
      csr_data_base <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      walk_base = value;
   endtask

   task automatic wait_drained();
      while (req_pending.size() != 0 || req_valid || seg_expect.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: idle_pct = 20;
            1: begin
               write_base(24'hffffff);
               idle_pct = 35;
            end
            2: begin
               write_base(24'h000000);
               idle_pct = 0;
            end
            3: begin
               write_base(fcw_pkg::BASE_W'($urandom));
               idle_pct = 10;
            end
            4: begin
               write_base(fcw_pkg::BASE_W'($urandom));
               idle_pct = 50;
            end
            default: begin
               write_base(fcw_pkg::DATA_BASE_RESET);
               idle_pct = 0;
            end
         endcase
         plan_items = 0;
         if (phase == 0) begin
            queue_directed();
         end
         while (plan_items < PHASE_ITEMS) begin
            if ($urandom_range(4) != 0) begin
               queue_file(($urandom_range(7) == 0) ? $urandom_range(9, 30)
                                                   : $urandom_range(1, 8));
            end else begin
               queue_noise();
            end
         end
         wait_drained();
      end
      if (seg_expect.size() != 0) begin
         note_failure($sformatf("%0d responses never arrived", seg_expect.size()));
      end
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
